>>> sv/matrix_local_minimum_counter_defines.svh
// Assertion macros for the matrix local-minimum counter.
// Included by the top level; needs no other file.
`ifndef MATRIX_LOCAL_MINIMUM_COUNTER_DEFINES_SVH
`define MATRIX_LOCAL_MINIMUM_COUNTER_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define MLMC_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// A condition that must hold in the cycle after the trigger.
`define MLMC_ASSERT_NEXT(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error(msg);

`endif

>>> sv/mlmc_pkg.sv
// Shared types and constants for the matrix local-minimum counter.
// Used by the cell and the top level; depends on nothing.
`default_nettype none

package mlmc_pkg;

  // Widths fixed by the register and result formats.
  localparam int CFG_W   = 7;
  localparam int CFG_MAX = 127;
  localparam int COUNT_W = 13;
  localparam int PEND_W  = 7;

  // Configuration register indexes.
  localparam logic [0:0] CFG_ROW_COUNT    = 1'b0;
  localparam logic [0:0] CFG_COLUMN_COUNT = 1'b1;

  // Control broadcast to every cell.
  typedef struct packed {
    logic accept;      // an element transfer happens this cycle
    logic up_valid;    // the current row has a row above it
    logic row_restart; // the current element ends its row
    logic new_flag;    // final candidate flag of the current element
  } cell_ctrl_t;

  // Status returned by each cell.
  typedef struct packed {
    logic new_clear; // the current element is greater than this neighbor
    logic settle;    // this cell's up element is settled as a minimum
    logic pending;   // this cell's left element keeps its candidate flag
  } cell_stat_t;

endpackage

`default_nettype wire

>>> sv/mlmc_cell.sv
// One column cell of the line: stored value, candidate flag and column token.
// Depends on mlmc_pkg for the control and status structs.
`default_nettype none

module mlmc_cell
  import mlmc_pkg::*;
#(
  parameter int VALUE_WIDTH = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire cell_ctrl_t             ctrl,
  input  wire logic [VALUE_WIDTH-1:0] element_value,
  input  wire logic                   tok_first,
  input  wire logic                   tok_left,
  input  wire logic                   tok_right,
  output logic                        token,
  output cell_stat_t                  stat
);

  logic [VALUE_WIDTH-1:0] value;
  logic                   flag;
  logic                   new_gt;
  logic                   old_gt;

  // Signed compare of the incoming element against the stored one.
  assign new_gt = $signed(element_value) > $signed(value);
  assign old_gt = $signed(value) > $signed(element_value);

  // The token marks the current column: this cell is the up neighbor when it
  // holds the token, and the left neighbor when the next cell holds it.
  assign stat.new_clear = (token & ctrl.up_valid & new_gt) | (tok_right & new_gt);
  assign stat.settle    = token & ctrl.up_valid & flag & ~old_gt;
  assign stat.pending   = tok_right & flag & ~old_gt;

  // The token moves one cell per transfer and returns to the first cell at row end.
  always_ff @(posedge clk) begin
    if (rst) begin
      token <= tok_first;
    end else if (ctrl.accept) begin
      token <= ctrl.row_restart ? tok_first : tok_left;
    end
  end

  // The current element overwrites the settled up element; the left element
  // loses its flag when the current one is strictly smaller.
  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      if (token) begin
        value <= element_value;
        flag  <= ctrl.new_flag;
      end else if (tok_right) begin
        flag <= flag & ~old_gt;
      end
    end
  end

endmodule

`default_nettype wire

>>> sv/matrix_local_minimum_counter.sv
// Result: the count is registered and appears in the cycle after the transfer of a frame's last element.
// Throughput: one element per cycle; the column cells compare and update in that cycle.
// Only a frame's last element waits, and only while an earlier count is still unclaimed.
// Reset: synchronous; dimensions return to 8 by 8, position and counts to zero.
// Line storage needs no clearing; it is written before it is read.
`default_nettype none

module matrix_local_minimum_counter
  import mlmc_pkg::*;
#(
  parameter int MAX_DIM     = 64,
  parameter int VALUE_WIDTH = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_write,
  input  wire logic [0:0]             cfg_index,
  input  wire logic [CFG_W-1:0]       cfg_data,
  input  wire logic                   element_valid,
  output logic                        element_stall,
  input  wire logic [VALUE_WIDTH-1:0] element_value,
  output logic                        count_valid,
  input  wire logic                   count_stall,
  output logic [COUNT_W-1:0]          local_min_count
);

  localparam int POS_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int CMP_W = ((POS_W > CFG_W) ? POS_W : CFG_W) + 1;
  localparam logic [CFG_W-1:0] DIM_LIMIT = CFG_W'((MAX_DIM > CFG_MAX) ? CFG_MAX : MAX_DIM);

  logic [CFG_W-1:0]   frame_rows;
  logic [CFG_W-1:0]   column_count;
  logic [CFG_W-1:0]   rows_eff;
  logic [CFG_W-1:0]   cols_eff;
  logic [POS_W-1:0]   row_pos;
  logic [POS_W-1:0]   col_pos;
  logic [COUNT_W-1:0] settled_count;
  logic [COUNT_W-1:0] settled_next;
  logic [PEND_W-1:0]  pending_count;
  logic [PEND_W-1:0]  pending_next;
  logic               row_end;
  logic               last_row;
  logic               frame_end;
  logic               accept;
  cell_ctrl_t         ctrl;
  logic [MAX_DIM-1:0] token_vec;
  logic [MAX_DIM-1:0] clear_vec;
  logic [MAX_DIM-1:0] settle_vec;
  logic [MAX_DIM-1:0] pending_vec;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_rows   <= CFG_W'(8);
      column_count <= CFG_W'(8);
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_ROW_COUNT:    frame_rows   <= cfg_data;
        CFG_COLUMN_COUNT: column_count <= cfg_data;
        default:          ;
      endcase
    end
  end

  // Dimensions clamped to the supported range.
  always_comb begin
    rows_eff = (frame_rows == '0) ? CFG_W'(1) :
               ((frame_rows > DIM_LIMIT) ? DIM_LIMIT : frame_rows);
    cols_eff = (column_count == '0) ? CFG_W'(1) :
               ((column_count > DIM_LIMIT) ? DIM_LIMIT : column_count);
  end

  // Position decode.
  assign row_end   = (CMP_W'(col_pos) + CMP_W'(1)) >= CMP_W'(cols_eff);
  assign last_row  = (CMP_W'(row_pos) + CMP_W'(1)) >= CMP_W'(rows_eff);
  assign frame_end = row_end & last_row;

  // Only the frame's last element needs room in the output register.
  assign element_stall = frame_end & count_valid & count_stall;
  assign accept        = element_valid & ~element_stall;

  // Broadcast control to the cells.
  assign ctrl.accept      = accept;
  assign ctrl.up_valid    = (row_pos != '0);
  assign ctrl.row_restart = row_end;
  assign ctrl.new_flag    = ~|clear_vec;

  // Row of column cells; the token is handed from each cell to the next.
  for (genvar j = 0; j < MAX_DIM; j++) begin : g_cell
    logic tok_left;
    logic tok_right;
    cell_stat_t stat;

    if (j == 0) begin : g_first
      assign tok_left = 1'b0;
    end else begin : g_inner
      assign tok_left = token_vec[j-1];
    end
    if (j == MAX_DIM - 1) begin : g_last
      assign tok_right = 1'b0;
    end else begin : g_mid
      assign tok_right = token_vec[j+1];
    end

    mlmc_cell #(
      .VALUE_WIDTH(VALUE_WIDTH)
    ) u_cell (
      .clk          (clk),
      .rst          (rst),
      .ctrl         (ctrl),
      .element_value(element_value),
      .tok_first    ((j == 0) ? 1'b1 : 1'b0),
      .tok_left     (tok_left),
      .tok_right    (tok_right),
      .token        (token_vec[j]),
      .stat         (stat)
    );

    assign clear_vec[j]   = stat.new_clear;
    assign settle_vec[j]  = stat.settle;
    assign pending_vec[j] = stat.pending;
  end

  // Running counts after this element.
  always_comb begin
    settled_next = settled_count + COUNT_W'(|settle_vec);
    pending_next = pending_count + PEND_W'(|pending_vec);
    if (row_end) begin
      pending_next = pending_next + PEND_W'(ctrl.new_flag);
    end
  end

  // Position and count registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_pos       <= '0;
      col_pos       <= '0;
      settled_count <= '0;
      pending_count <= '0;
    end else if (accept) begin
      if (frame_end) begin
        row_pos       <= '0;
        col_pos       <= '0;
        settled_count <= '0;
        pending_count <= '0;
      end else if (row_end) begin
        row_pos       <= row_pos + POS_W'(1);
        col_pos       <= '0;
        settled_count <= settled_next;
        pending_count <= '0;
      end else begin
        col_pos       <= col_pos + POS_W'(1);
        settled_count <= settled_next;
        pending_count <= pending_next;
      end
    end
  end

  // Output register: loaded at frame end, released on transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      count_valid <= 1'b0;
    end else if (accept && frame_end) begin
      count_valid <= 1'b1;
    end else if (!count_stall) begin
      count_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && frame_end) begin
      local_min_count <= settled_next + COUNT_W'(pending_next);
    end
  end

  // Checks on the column token and the result path.
  `include "matrix_local_minimum_counter_defines.svh"

  `MLMC_ASSERT_ALWAYS(a_token_onehot, $onehot(token_vec), "column token is not one-hot")
  `MLMC_ASSERT_ALWAYS(a_token_at_col, token_vec[col_pos], "column token off its position")
  `MLMC_ASSERT_NEXT(a_frame_result, accept && frame_end, count_valid, "frame end gave no count")

endmodule

`default_nettype wire
